>>> hdl/red_pkg.sv
// ----------------------------------------------------------------------------
// red_pkg: shared types, constants and helpers for reflectance error diffusion
// Fixed-point formats, state encodings and the error share arithmetic.
// ----------------------------------------------------------------------------
package red_pkg;

  // default line store depth (pixels per row)
  localparam int LINE_MAX_DEF = 512;
  localparam int HEIGHT_MAX   = 4096;

  // register reset values
  localparam logic [9:0]  WIDTH_RST  = 10'd400;
  localparam logic [12:0] HEIGHT_RST = 13'd400;
  localparam logic [16:0] THRESH_RST = 17'd26214;   // 0.4 in Q1.16

  // reflectance range, unsigned Q2.16
  localparam logic [17:0] REFL_MAX = 18'h3FFFF;
  localparam logic signed [21:0] ONE_Q16 = 22'sd65536;

  // stored error limits, signed Q3.16
  localparam logic signed [19:0] ERR_MAX = 20'sd524287;
  localparam logic signed [19:0] ERR_MIN = -20'sd524288;

  // Floyd-Steinberg weights, in sixteenths
  localparam logic [2:0] W_RIGHT       = 3'd7;
  localparam logic [2:0] W_BELOW_LEFT  = 3'd3;
  localparam logic [2:0] W_BELOW       = 3'd5;
  localparam logic [2:0] W_BELOW_RIGHT = 3'd1;

  // iteration counts of the reflectance unit
  localparam int DIV_STEPS  = 36;
  localparam int SQRT_STEPS = 18;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_THRESH = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_REFL,
    S_ACC,
    S_DIFF,
    S_SHARE,
    S_WRITE,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    R_IDLE,
    R_DIV,
    R_SQRT,
    R_DONE
  } refl_state_t;

  // floor(w * d / 16)
  function automatic logic signed [23:0] share_w(input logic signed [21:0] d,
                                                 input logic [2:0] w);
    logic signed [27:0] p;
    p = 28'(d) * $signed({25'd0, w});
    return p[27:4];
  endfunction

  // clamp to the 20-bit signed error range
  function automatic logic signed [19:0] sat20(input logic signed [23:0] v);
    logic signed [19:0] r;
    if (v > 24'(ERR_MAX))
      r = ERR_MAX;
    else if (v < 24'(ERR_MIN))
      r = ERR_MIN;
    else
      r = v[19:0];
    return r;
  endfunction

endpackage

>>> hdl/red_sub_unit.sv
// ----------------------------------------------------------------------------
// red_sub_unit: shared subtract and compare
// One 21-bit subtractor with borrow, shared by the divide and root steps.
// ----------------------------------------------------------------------------
module red_sub_unit (
  input  logic [20:0] a,
  input  logic [20:0] b,
  output logic [20:0] diff,
  output logic        ge
);

  logic [21:0] full;

  assign full = {1'b0, a} - {1'b0, b};
  assign diff = full[20:0];
  assign ge   = ~full[21];

endmodule

>>> hdl/red_refl_unit.sv
// ----------------------------------------------------------------------------
// red_refl_unit: reflectance sequencer
// sqrt(target / beam) in Q2.16: restoring divide then digit-by-digit root,
// one bit a cycle on the shared subtractor.
// ----------------------------------------------------------------------------
module red_refl_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] target_level,
  input  logic [15:0] beam_level,
  output logic        done,
  output logic [17:0] refl
);

  red_pkg::refl_state_t rs, rs_next;

  logic [20:0] rem;
  logic [17:0] root;
  logic [35:0] quo;
  logic [5:0]  cnt;
  logic [15:0] tgt;
  logic [15:0] bm;

  logic [20:0] op_a, op_b, diff;
  logic        ge;
  logic        nbit;
  logic        zero_in, sat_in;

  red_sub_unit u_sub (
    .a    (op_a),
    .b    (op_b),
    .diff (diff),
    .ge   (ge)
  );

  assign nbit    = cnt[5] ? tgt[cnt[1:0]] : 1'b0;
  assign zero_in = (target_level == 16'd0) || (beam_level == 16'd0);
  // quotient reaches 2^36 exactly when target >= 16 * beam
  assign sat_in  = {4'd0, target_level} >= {beam_level, 4'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      rs <= red_pkg::R_IDLE;
    end else begin
      rs <= rs_next;
    end
  end

  always_comb begin
    rs_next = rs;
    done    = 1'b0;
    op_a    = '0;
    op_b    = '0;
    case (rs)
      red_pkg::R_IDLE: begin
        if (start) begin
          rs_next = (zero_in || sat_in) ? red_pkg::R_DONE : red_pkg::R_DIV;
        end
      end
      red_pkg::R_DIV: begin
        op_a = {4'd0, rem[15:0], nbit};
        op_b = {5'd0, bm};
        if (cnt == 6'd0) rs_next = red_pkg::R_SQRT;
      end
      red_pkg::R_SQRT: begin
        op_a = {rem[18:0], quo[35:34]};
        op_b = {1'b0, root, 2'b01};
        if (cnt == 6'd0) rs_next = red_pkg::R_DONE;
      end
      red_pkg::R_DONE: begin
        done    = 1'b1;
        rs_next = red_pkg::R_IDLE;
      end
      default: rs_next = red_pkg::R_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (rs)
      red_pkg::R_IDLE: begin
        if (start) begin
          tgt  <= target_level;
          bm   <= beam_level;
          rem  <= {9'd0, target_level[15:4]};
          quo  <= '0;
          cnt  <= 6'(red_pkg::DIV_STEPS - 1);
          refl <= zero_in ? 18'd0 : red_pkg::REFL_MAX;
        end
      end
      red_pkg::R_DIV: begin
        quo <= {quo[34:0], ge};
        if (cnt == 6'd0) begin
          rem  <= '0;
          root <= '0;
          cnt  <= 6'(red_pkg::SQRT_STEPS - 1);
        end else begin
          rem <= ge ? diff : op_a;
          cnt <= cnt - 6'd1;
        end
      end
      red_pkg::R_SQRT: begin
        rem  <= ge ? diff : op_a;
        root <= {root[16:0], ge};
        quo  <= {quo[33:0], 2'b00};
        cnt  <= cnt - 6'd1;
        if (cnt == 6'd0) refl <= {root[16:0], ge};
      end
      default: begin
      end
    endcase
  end

endmodule

>>> hdl/red_line_mem.sv
// ----------------------------------------------------------------------------
// red_line_mem: next-row error store
// Single write port, single registered read port.
// ----------------------------------------------------------------------------
module red_line_mem #(
  parameter int DEPTH = red_pkg::LINE_MAX_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [19:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [19:0]   rdata
);

  logic [19:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

>>> hdl/reflectance_error_diffusion_core.sv
// ----------------------------------------------------------------------------
// reflectance_error_diffusion_core: binary mirror pattern by error diffusion
// Pixels: one at a time; a new request is taken only once the last result
//   is in the output register. Divide and root are skipped when beam or
//   target is zero or the ratio saturates. The reflectance is bit-serial,
//   divide (36 steps) then root (18 steps) on the one shared subtractor.
// Reset: synchronous; registers to defaults, position and carries to zero,
//   error store emptied at once through its fill count (no clearing pass).
// ----------------------------------------------------------------------------
module reflectance_error_diffusion_core #(
  parameter int LINE_MAX = red_pkg::LINE_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // pixel input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,    // [15:0] target_level, [31:16] beam_level
  // mirror output
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,    // [0] mirror_on, [7:1] zero
  // register writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  localparam int CW   = $clog2(LINE_MAX);      // column index bits
  localparam int CNTW = CW + 1;                // counts up to LINE_MAX
  localparam int WW   = (CNTW > 10) ? CNTW : 10;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  logic [9:0]  frame_width;
  logic [12:0] frame_height;
  logic [16:0] on_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= red_pkg::WIDTH_RST;
      frame_height <= red_pkg::HEIGHT_RST;
      on_threshold <= red_pkg::THRESH_RST;
    end else if (cfg_we) begin
      case (red_pkg::cfg_idx_t'(cfg_index))
        red_pkg::CFG_WIDTH:  frame_width  <= cfg_data[9:0];
        red_pkg::CFG_HEIGHT: frame_height <= cfg_data[12:0];
        red_pkg::CFG_THRESH: on_threshold <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // effective frame size: zero reads as one, oversize clamps
  logic [WW-1:0]   width_ext;
  logic [CNTW-1:0] wc;
  logic [12:0]     hc;

  assign width_ext = WW'(frame_width);

  always_comb begin
    if (frame_width == 10'd0)
      wc = CNTW'(1);
    else if (width_ext > WW'(LINE_MAX))
      wc = CNTW'(LINE_MAX);
    else
      wc = CNTW'(frame_width);

    if (frame_height == 13'd0)
      hc = 13'd1;
    else if (frame_height > 13'(red_pkg::HEIGHT_MAX))
      hc = 13'(red_pkg::HEIGHT_MAX);
    else
      hc = frame_height;
  end

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  red_pkg::state_t state, state_next;

  logic [15:0]            tgt, bm;
  logic [CW-1:0]          col;
  logic [11:0]            row;
  logic [CNTW-1:0]        fill;       // store entries written this frame
  logic signed [19:0]     right;      // carry to the next pixel in the row
  logic signed [19:0]     diag;       // 1/16 share for next row, next column
  logic signed [19:0]     pend;       // last value written to the store
  logic signed [19:0]     five;       // below share waiting to be written
  logic signed [21:0]     vsum;
  logic signed [21:0]     dval;
  logic                   bit_on;
  logic                   last_row;
  logic                   has_right;
  logic                   mirror;

  // reflectance unit
  logic        refl_start, refl_done;
  logic [17:0] refl;

  red_refl_unit u_refl (
    .clk          (clk),
    .rst          (rst),
    .start        (refl_start),
    .target_level (tgt),
    .beam_level   (bm),
    .done         (refl_done),
    .refl         (refl)
  );

  // error store
  logic          mem_we, mem_re;
  logic [CW-1:0] mem_waddr, mem_raddr;
  logic [19:0]   mem_wdata, mem_rdata;

  red_line_mem #(
    .DEPTH (LINE_MAX),
    .AW    (CW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // --------------------------------------------------------------------------
  // Position on request: wrap a stale column or row (size may have shrunk)
  // --------------------------------------------------------------------------
  logic            col_wrap;
  logic [12:0]     row_inc;
  logic [12:0]     row_e13;
  logic [11:0]     row_e;
  logic [CW-1:0]   col_e;
  logic            frame_st;

  assign col_wrap = {1'b0, col} >= wc;
  assign row_inc  = col_wrap ? 13'(row) + 13'd1 : 13'(row);
  assign row_e13  = (row_inc >= hc) ? 13'd0 : row_inc;
  assign row_e    = row_e13[11:0];
  assign col_e    = col_wrap ? '0 : col;
  assign frame_st = (col_e == '0) && (row_e == 12'd0);

  // advance after the pixel
  logic [CNTW-1:0] col_p1;
  logic [12:0]     row_p1;

  assign col_p1 = {1'b0, col} + CNTW'(1);
  assign row_p1 = 13'(row) + 13'd1;

  // error arithmetic
  logic signed [19:0] nre;
  logic signed [19:0] below_left;
  logic signed [19:0] below_val;

  // entries past the fill count are not yet written this frame and read as zero
  assign nre        = ({1'b0, col} < fill) ? $signed(mem_rdata) : 20'sd0;
  assign below_left = red_pkg::sat20(24'(pend)
                      + red_pkg::share_w(dval, red_pkg::W_BELOW_LEFT));
  assign below_val  = last_row ? 20'sd0 : five;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= red_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    refl_start = 1'b0;
    mem_re     = 1'b0;
    mem_raddr  = col_e;
    mem_we     = 1'b0;
    mem_waddr  = col;
    mem_wdata  = below_val;
    case (state)
      red_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = red_pkg::S_PREP;
      end
      red_pkg::S_PREP: begin
        refl_start = 1'b1;
        mem_re     = 1'b1;
        state_next = red_pkg::S_REFL;
      end
      red_pkg::S_REFL: begin
        if (refl_done) state_next = red_pkg::S_ACC;
      end
      red_pkg::S_ACC:   state_next = red_pkg::S_DIFF;
      red_pkg::S_DIFF:  state_next = red_pkg::S_SHARE;
      red_pkg::S_SHARE: begin
        // 3/16 onto the entry left behind, unless on the last row or at column zero
        mem_we     = !last_row && (col != '0);
        mem_waddr  = col - CW'(1);
        mem_wdata  = below_left;
        state_next = red_pkg::S_WRITE;
      end
      red_pkg::S_WRITE: begin
        mem_we     = 1'b1;
        state_next = red_pkg::S_OUT;
      end
      red_pkg::S_OUT: begin
        if (!m_tvalid || m_tready) state_next = red_pkg::S_IDLE;
      end
      default: state_next = red_pkg::S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      col   <= '0;
      row   <= '0;
      fill  <= '0;
      right <= '0;
      diag  <= '0;
    end else begin
      case (state)
        red_pkg::S_PREP: begin
          col <= col_e;
          row <= row_e;
          if (col_wrap || frame_st) begin
            right <= '0;
            diag  <= '0;
          end
          if (frame_st) fill <= '0;
        end
        red_pkg::S_WRITE: begin
          if (col_p1 > fill) fill <= col_p1;
          if (has_right) begin
            right <= red_pkg::sat20(red_pkg::share_w(dval, red_pkg::W_RIGHT));
            diag  <= last_row ? 20'sd0
                     : red_pkg::sat20(red_pkg::share_w(dval, red_pkg::W_BELOW_RIGHT));
          end else begin
            right <= '0;
            diag  <= '0;
          end
          if (col_p1 >= wc) begin
            col <= '0;
            row <= (row_p1 >= hc) ? 12'd0 : row_p1[11:0];
          end else begin
            col <= col_p1[CW-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      red_pkg::S_IDLE: begin
        if (s_tvalid) begin
          tgt <= s_tdata[15:0];
          bm  <= s_tdata[31:16];
        end
      end
      red_pkg::S_PREP: begin
        last_row  <= (13'(row_e) + 13'd1) >= hc;
        has_right <= (CNTW'(col_e) + CNTW'(1)) < wc;
      end
      red_pkg::S_ACC: begin
        vsum <= 22'($signed({1'b0, refl})) + 22'(right) + 22'(nre);
      end
      red_pkg::S_DIFF: begin
        bit_on <= vsum > $signed({5'd0, on_threshold});
        dval   <= (vsum > $signed({5'd0, on_threshold})) ? vsum - red_pkg::ONE_Q16
                                                         : vsum;
      end
      red_pkg::S_SHARE: begin
        five <= red_pkg::sat20(24'(diag) + red_pkg::share_w(dval, red_pkg::W_BELOW));
      end
      red_pkg::S_WRITE: begin
        pend <= below_val;
      end
      red_pkg::S_OUT: begin
        if (!m_tvalid || m_tready) mirror <= bit_on;
      end
      default: begin
      end
    endcase
  end

  // output register: holds the result until the far side takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == red_pkg::S_OUT && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {7'd0, mirror};

`ifndef SYNTH
  // the left-neighbour update never targets a column before the first
  a_left_write_col: assert property (@(posedge clk) disable iff (rst)
    (state == red_pkg::S_SHARE && mem_we) |-> (col != '0))
    else $error("below-left write at column zero");

  // the reflectance unit only finishes while it is being waited on
  a_refl_done_wait: assert property (@(posedge clk) disable iff (rst)
    refl_done |-> (state == red_pkg::S_REFL))
    else $error("reflectance done outside wait state");

  // a new result appears only from the output state
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == red_pkg::S_OUT))
    else $error("result raised outside output state");

  // the pixel just finished has been counted into the store
  a_fill_counted: assert property (@(posedge clk) disable iff (rst)
    (state == red_pkg::S_OUT) |-> (fill != '0))
    else $error("fill count empty after store write");
`endif

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for reflectance_error_diffusion_core
// Pixel requests go in on the slave stream and each mirror bit comes back on
// the master stream. A behavioural model of the square-root reflectance and
// Floyd-Steinberg diffusion predicts each bit the probe table does not type. A short table of probes comes
// first, then random pixels over a sweep of frame sizes and thresholds.
// ----------------------------------------------------------------------------
module tb;

  localparam int WATCHDOG_LIMIT = 3000;   // cycles with no request moving
  localparam int TAIL_CYCLES    = 100;    // idle run after the last result
  localparam int USE_MODEL      = -1;     // probe row has no typed result

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;
  always #10 clk = ~clk;

  // block ports
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata   = '0;    // [15:0] target_level, [31:16] beam_level
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [7:0]  m_tdata;           // [0] mirror_on, [7:1] zero
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [16:0] cfg_data  = '0;

  reflectance_error_diffusion_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Model state: register copies, error line store, carries and position
  // --------------------------------------------------------------------------
  logic [9:0]         width_reg  = red_pkg::WIDTH_RST;
  logic [12:0]        height_reg = red_pkg::HEIGHT_RST;
  logic [16:0]        thresh_reg = red_pkg::THRESH_RST;
  logic signed [19:0] below_err [red_pkg::LINE_MAX_DEF];
  logic signed [19:0] right_err;
  logic signed [19:0] diag_err;
  int                 col_pos;
  int                 row_pos;

  // mirror bits owed by the block, oldest first
  logic mirror_due [$];
  int   mismatch_count = 0;
  int   pixels_sent    = 0;
  int   tx_idle_pct    = 13;
  int   rx_idle_pct    = 84;

  function automatic void clear_errors();
    for (int i = 0; i < red_pkg::LINE_MAX_DEF; i++)
      below_err[i] = '0;
    right_err = '0;
    diag_err  = '0;
  endfunction

  // sqrt(target / beam) in Q2.16, truncated, clamped to the reflectance range
  function automatic logic [17:0] refl_q16(input logic [15:0] t, input logic [15:0] b);
    logic [63:0] ratio;
    logic [63:0] root;
    logic [63:0] probe;
    if (t == 0 || b == 0)
      return '0;
    ratio = {16'd0, t, 32'd0} / {48'd0, b};
    root  = '0;
    probe = 64'd1 << 62;
    while (probe > ratio)
      probe = probe >> 2;
    while (probe != 0) begin
      if (ratio >= root + probe) begin
        ratio = ratio - (root + probe);
        root  = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    if (root > 64'(red_pkg::REFL_MAX))
      return red_pkg::REFL_MAX;
    return root[17:0];
  endfunction

  // floor(weight * d / 16); arithmetic shift rounds toward minus infinity
  function automatic longint sixteenths(input longint d, input int weight);
    return (d * weight) >>> 4;
  endfunction

  function automatic logic signed [19:0] clamp_err(input longint x);
    if (x > longint'(red_pkg::ERR_MAX))
      return red_pkg::ERR_MAX;
    if (x < longint'(red_pkg::ERR_MIN))
      return red_pkg::ERR_MIN;
    return x[19:0];
  endfunction

  // Advances the diffusion model by one pixel and returns the mirror bit
  function automatic logic mirror_from_pixel(input logic [15:0] t, input logic [15:0] b);
    int     w;
    int     h;
    int     c;
    longint acc;
    longint resid;
    logic   on;
    logic   last_row;
    logic   has_right;
    w = (width_reg == 0) ? 1
        : (width_reg > red_pkg::LINE_MAX_DEF) ? red_pkg::LINE_MAX_DEF : int'(width_reg);
    h = (height_reg == 0) ? 1
        : (height_reg > red_pkg::HEIGHT_MAX) ? red_pkg::HEIGHT_MAX : int'(height_reg);

    // a size change mid-frame can leave the position out of range
    if (col_pos >= w) begin
      col_pos   = 0;
      row_pos++;
      right_err = '0;
      diag_err  = '0;
    end
    if (row_pos >= h)
      row_pos = 0;
    if (col_pos == 0 && row_pos == 0)
      clear_errors();

    c         = col_pos;
    last_row  = (row_pos + 1 >= h);
    has_right = (c + 1 < w);

    acc   = longint'(refl_q16(t, b)) + longint'(right_err) + longint'(below_err[c]);
    on    = acc > longint'(thresh_reg);
    resid = acc - (on ? 64'sd65536 : 64'sd0);

    if (last_row) begin
      below_err[c] = '0;
    end else begin
      if (c > 0)
        below_err[c-1] = clamp_err(longint'(below_err[c-1])
                                   + sixteenths(resid, red_pkg::W_BELOW_LEFT));
      below_err[c] = clamp_err(longint'(diag_err) + sixteenths(resid, red_pkg::W_BELOW));
    end
    if (has_right) begin
      right_err = clamp_err(sixteenths(resid, red_pkg::W_RIGHT));
      diag_err  = last_row ? 20'sd0
                  : clamp_err(sixteenths(resid, red_pkg::W_BELOW_RIGHT));
    end else begin
      right_err = '0;
      diag_err  = '0;
    end

    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h)
        row_pos = 0;
    end
    return on;
  endfunction

  // --------------------------------------------------------------------------
  // Checker: every result against the oldest owed bit
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    logic want;
    if (!rst && m_tvalid && m_tready) begin
      if (mirror_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result, tdata %02h", m_tdata));
      end else begin
        want = mirror_due.pop_front();
        if (m_tdata[0] !== want)
          report_mismatch($sformatf("mirror_on %b, expected %b", m_tdata[0], want));
        if (m_tdata[7:1] !== 7'd0)
          report_mismatch($sformatf("tdata padding %02h not zero", m_tdata));
      end
    end
  end

  // receiver back-pressure, re-drawn every cycle
  always @(negedge clk)
    m_tready <= ($urandom_range(99) >= rx_idle_pct);

  // watchdog: ends the run when no request has moved for too long
  always @(posedge clk) begin
    int quiet;
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("%0t ns: timeout, no request moved for %0d cycles", $time, quiet);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_pixel(input logic [15:0] t, input logic [15:0] b, input int known);
    logic on;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {b, t};
    @(posedge clk);
    while (!s_tready)
      @(posedge clk);
    on = mirror_from_pixel(t, b);
    mirror_due.push_back(known < 0 ? on : known[0]);
    pixels_sent++;
    // idling: sender light / receiver heavy, then swapped, then none
    if (pixels_sent == 350) begin
      tx_idle_pct = 84;
      rx_idle_pct = 13;
    end else if (pixels_sent == 700) begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
    @(negedge clk);
  endtask

  // sender holds off until every owed bit has come back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (mirror_due.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(input red_pkg::cfg_idx_t idx, input logic [16:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      red_pkg::CFG_WIDTH:  width_reg  = val[9:0];
      red_pkg::CFG_HEIGHT: height_reg = val[12:0];
      red_pkg::CFG_THRESH: thresh_reg = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // random pixel, weighted towards realistic ratios with the corner cases mixed in
  task automatic pick_pixel(output logic [15:0] t, output logic [15:0] b);
    t = 16'($urandom);
    b = 16'($urandom);
    case ($urandom_range(9))
      0: t = '0;                                    // dark target
      1: b = '0;                                    // no beam
      2: ;                                          // anything
      3: b = 16'($urandom_range(15));               // ratio saturates
      4: t = b;                                     // reflectance one
      default: begin                                // reflectance below one
        b = 16'($urandom_range(65535, 32768));
        t = 16'($urandom_range(b));
      end
    endcase
  endtask

  typedef struct packed {
    logic [15:0] target;
    logic [15:0] beam;
    int          known;   // typed mirror bit, or USE_MODEL
  } probe_t;

  // reset settings: 400 x 400, threshold 0.4; all of row 0
  localparam probe_t PROBES [18] = '{
    '{16'h0000, 16'h0000, 0},           // both zero
    '{16'h0000, 16'hFFFF, 0},           // dark target, full beam
    '{16'hFFFF, 16'h0000, 0},           // no beam
    '{16'h0000, 16'h0001, 0},
    '{16'hFFFF, 16'h0001, 1},           // ratio saturates, no error yet
    '{16'h0001, 16'hFFFF, USE_MODEL},
    '{16'hFFFF, 16'hFFFF, USE_MODEL},   // reflectance exactly one
    '{16'h8000, 16'hFFFF, USE_MODEL},
    '{16'h0001, 16'h0001, USE_MODEL},
    '{16'hFFFF, 16'hFFFE, USE_MODEL},
    '{16'h4000, 16'hFFFF, USE_MODEL},   // about one half
    '{16'h28F6, 16'hFFFF, USE_MODEL},   // near the default threshold
    '{16'hFFFF, 16'h3FFF, USE_MODEL},   // just over two
    '{16'hFFFF, 16'h0FFF, USE_MODEL},   // four, clamps
    '{16'h1000, 16'h0001, USE_MODEL},
    '{16'hAAAA, 16'h5555, USE_MODEL},
    '{16'h5555, 16'hAAAA, USE_MODEL},
    '{16'hFFFF, 16'h0001, USE_MODEL}
  };

  typedef struct packed {
    int width;
    int height;
    int thresh;
    int count;
  } sweep_t;

  // counts are not frame multiples, so sizes also change mid-frame
  localparam sweep_t SWEEPS [7] = '{
    '{5,    3,    26214,  118},
    '{1,    4,    0,      40},    // single column, lowest threshold
    '{0,    0,    131071, 40},    // zero sizes act as one, highest threshold
    '{16,   8,    65536,  150},
    '{3,    2,    100000, 110},
    '{512,  2,    40000,  540},   // full line store
    '{1023, 8191, 26214,  30}     // oversize, clamped to the limits
  };

  initial begin
    logic [15:0] t;
    logic [15:0] b;
    clear_errors();
    col_pos = 0;
    row_pos = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (PROBES[i])
      send_pixel(PROBES[i].target, PROBES[i].beam, PROBES[i].known);

    foreach (SWEEPS[i]) begin
      wait_drained();
      write_reg(red_pkg::CFG_WIDTH,  17'(SWEEPS[i].width));
      write_reg(red_pkg::CFG_HEIGHT, 17'(SWEEPS[i].height));
      write_reg(red_pkg::CFG_THRESH, 17'(SWEEPS[i].thresh));
      for (int n = 0; n < SWEEPS[i].count; n++) begin
        pick_pixel(t, b);
        send_pixel(t, b, USE_MODEL);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && mirror_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
